// File: hdl/smia_pkg.sv
// ----------------------------------------------------------------------------
// smia_pkg: shared constants and helpers for the small matrix inverse
// Q16.16 widths, default size and 32-bit saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package smia_pkg;

  localparam int unsigned DimDef = 4;     // default matrix size
  localparam int unsigned QW     = 32;    // Q16.16 word width
  localparam int unsigned FracW  = 16;    // fraction bits
  localparam int unsigned TermW  = 48;    // rounded product width
  localparam int unsigned AccW   = 52;    // exact sum of up to 8 terms
  localparam int unsigned DivW   = 48;    // |cofactor| << 16

  localparam logic signed [QW-1:0] OneQ = 32'sh0001_0000;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [QW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(64'sh0000_0000_7FFF_FFFF);
    lo = AccW'(-64'sh0000_0000_8000_0000);
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[QW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/small_matrix_inverse_adjugate_top.sv
// ----------------------------------------------------------------------------
// small_matrix_inverse_adjugate_top: Q16.16 matrix inverse by adjugate
// Loads a DIM x DIM matrix, finds det by cofactor expansion, emits inverse.
// ----------------------------------------------------------------------------
//
//  channel   dir  width  contents (low bit first)
//  s_axis    in   32     tdata: element
//  m_axis    out  72     tdata: value[31:0] row[33:32] col[35:34]
//                        det_value[67:36] pad; tuser: singular; tlast: last
//
// Load takes an element on each valid beat. The minor evaluator then walks the
// cofactor tree from memory, with a read and a data state per node and a
// multiply and accumulate state per multiply-add. Each inverse element runs the
// divider (sign, setup, 48 quotient steps, rounding); singular: input echoed.
// Reset clears the FSM and load count; the matrix memory needs no clearing.
// Input is refused until all results are out; a stalled output holds still.
//
`default_nettype none

module small_matrix_inverse_adjugate_top import smia_pkg::*; #(
  parameter int unsigned DIM = DimDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // element
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,   // value, row, col, det_value, pad
  output logic             m_axis_tuser_o,   // singular
  output logic             m_axis_tlast_o    // last
);

  localparam int unsigned Cells = DIM * DIM;
  localparam int unsigned AW    = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int unsigned LW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int unsigned MW    = DIM;
  localparam int unsigned CntW  = $clog2(DivW + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_RD, S_GOT, S_MUL, S_ACC, S_EVDONE,
    S_NEXT, S_SGOT, S_DIV, S_DFIN, S_OUT
  } state_e;

  state_e state_q;

  // matrix memory
  logic [QW-1:0] mem [Cells];
  logic [QW-1:0] rdata_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] load_cnt_q;

  // evaluator stack, one entry per level
  logic [MW-1:0]          mask_q [DIM];
  logic [LW-1:0]          col_q  [DIM];
  logic                   par_q  [DIM];
  logic signed [QW-1:0]   elem_q [DIM];
  logic signed [AccW-1:0] acc_q  [DIM];
  logic [LW-1:0]          lvl_q;

  logic                   det_mode_q;
  logic [LW-1:0]          skip_q;
  logic [MW-1:0]          mask0_q;
  logic                   empty_q;     // zero-size minor
  logic signed [QW-1:0]   val_q;       // value returned by a child
  logic signed [63:0]     prod_q;
  logic signed [QW-1:0]   res_q;       // finished minor

  logic signed [QW-1:0]   det_q;
  logic                   sing_q;
  logic [LW-1:0]          i_q, j_q;
  logic signed [QW-1:0]   cof_q;

  logic [DivW-1:0]        nq_q;        // dividend shifting out, quotient in
  logic [QW-1:0]          rem_q;
  logic [QW-1:0]          den_q;
  logic [CntW-1:0]        dcnt_q;

  logic signed [QW-1:0]   out_val_q;

  // row used by a level: all rows for det, all but skip_q for a cofactor
  function automatic logic [LW-1:0] row_of(input logic [LW-1:0] l, input logic dm,
                                           input logic [LW-1:0] sk);
    if (dm || (l < sk)) begin
      row_of = l;
    end else begin
      row_of = l + LW'(1);
    end
  endfunction

  function automatic logic [LW-1:0] lowest(input logic [MW-1:0] m);
    lowest = '0;
    for (int k = DIM - 1; k >= 0; k--) begin
      if (m[k]) lowest = LW'(k);
    end
  endfunction

  logic [LW-1:0] cur_row, cur_col, nxt_col, sub_first;
  logic          nxt_found, is_leaf;
  logic [MW-1:0] cur_mask, sub_mask;

  always_comb begin
    cur_mask  = mask_q[lvl_q];
    cur_col   = col_q[lvl_q];
    cur_row   = row_of(lvl_q, det_mode_q, skip_q);
    is_leaf   = ((cur_mask & (cur_mask - MW'(1))) == '0);
    sub_mask  = cur_mask & ~(MW'(1) << cur_col);
    sub_first = lowest(sub_mask);
    nxt_found = 1'b0;
    nxt_col   = '0;
    for (int k = DIM - 1; k >= 0; k--) begin
      if (cur_mask[k] && (LW'(k) > cur_col)) begin
        nxt_found = 1'b1;
        nxt_col   = LW'(k);
      end
    end
  end

  always_comb begin
    if (state_q == S_NEXT) begin
      rd_addr = AW'(int'(i_q) * DIM + int'(j_q));
    end else begin
      rd_addr = AW'(int'(cur_row) * DIM + int'(cur_col));
    end
  end

  // round half up, add/subtract into level sum; cofactor sign; divider terms
  logic signed [63:0]     prod_r;
  logic signed [TermW-1:0] term;
  logic signed [AccW-1:0] acc_new;
  logic signed [AccW-1:0] neg_res;
  logic signed [QW-1:0]   cof_d;
  logic [QW-1:0]          cof_mag;
  logic [QW:0]            rem_sh;
  logic [DivW:0]          qmag;
  logic signed [DivW+1:0] qsgn;
  logic                   qneg;

  always_comb begin
    prod_r  = (prod_q + 64'sd32768) >>> FracW;
    term    = prod_r[TermW-1:0];
    acc_new = par_q[lvl_q] ? (acc_q[lvl_q] - AccW'(term)) : (acc_q[lvl_q] + AccW'(term));
    neg_res = -AccW'(res_q);
    cof_d   = (i_q[0] ^ j_q[0]) ? sat32(neg_res) : res_q;
    cof_mag = cof_d[QW-1] ? QW'(-cof_d) : QW'(cof_d);
    rem_sh  = {rem_q, nq_q[DivW-1]};
    qmag    = {1'b0, nq_q} + (({rem_q, 1'b0} >= {1'b0, den_q}) ? (DivW+1)'(1) : '0);
    qneg    = cof_q[QW-1] ^ det_q[QW-1];
    qsgn    = qneg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && s_axis_tvalid_i) begin
      mem[load_cnt_q] <= s_axis_tdata_i;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      load_cnt_q <= '0;
      lvl_q      <= '0;
      det_mode_q <= 1'b1;
      sing_q     <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (s_axis_tvalid_i) begin
            if (load_cnt_q == AW'(Cells - 1)) begin
              load_cnt_q <= '0;
              det_mode_q <= 1'b1;
              skip_q     <= '0;
              mask0_q    <= '1;
              empty_q    <= 1'b0;
              state_q    <= S_START;
            end else begin
              load_cnt_q <= load_cnt_q + AW'(1);
            end
          end
        end
        S_START: begin
          if (empty_q) begin
            res_q   <= OneQ;
            state_q <= S_EVDONE;
          end else begin
            lvl_q     <= '0;
            mask_q[0] <= mask0_q;
            col_q[0]  <= lowest(mask0_q);
            par_q[0]  <= 1'b0;
            acc_q[0]  <= '0;
            state_q   <= S_RD;
          end
        end
        S_RD: state_q <= S_GOT;   // address issued, data next cycle
        S_GOT: begin
          if (is_leaf) begin
            if (lvl_q == '0) begin
              res_q   <= rdata_q;
              state_q <= S_EVDONE;
            end else begin
              val_q   <= rdata_q;
              lvl_q   <= lvl_q - LW'(1);
              state_q <= S_MUL;
            end
          end else begin
            elem_q[lvl_q]          <= rdata_q;
            mask_q[lvl_q + LW'(1)] <= sub_mask;
            col_q[lvl_q + LW'(1)]  <= sub_first;
            par_q[lvl_q + LW'(1)]  <= 1'b0;
            acc_q[lvl_q + LW'(1)]  <= '0;
            lvl_q                  <= lvl_q + LW'(1);
            state_q                <= S_RD;
          end
        end
        S_MUL: begin
          prod_q  <= elem_q[lvl_q] * val_q;
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (nxt_found) begin
            acc_q[lvl_q] <= acc_new;
            col_q[lvl_q] <= nxt_col;
            par_q[lvl_q] <= ~par_q[lvl_q];
            state_q      <= S_RD;
          end else if (lvl_q == '0) begin
            res_q   <= sat32(acc_new);
            state_q <= S_EVDONE;
          end else begin
            val_q   <= sat32(acc_new);
            lvl_q   <= lvl_q - LW'(1);
            state_q <= S_MUL;
          end
        end
        S_EVDONE: begin
          if (det_mode_q) begin
            det_q   <= res_q;
            sing_q  <= (res_q == '0);
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_NEXT;
          end else begin
            // cofactor sign, then |cof| << 16 as the dividend
            cof_q   <= cof_d;
            nq_q    <= {cof_mag, {FracW{1'b0}}};
            state_q <= S_DIV;
          end
        end
        S_NEXT: begin
          if (sing_q) begin
            state_q <= S_SGOT;
          end else begin
            det_mode_q <= 1'b0;
            skip_q     <= j_q;
            mask0_q    <= ~(MW'(1) << i_q);
            empty_q    <= (DIM == 1);
            state_q    <= S_START;
          end
        end
        S_SGOT: begin
          out_val_q <= rdata_q;
          state_q   <= S_OUT;
        end
        S_DIV: begin
          // setup pass: |det|, clear remainder and step count
          den_q   <= det_q[QW-1] ? QW'(-det_q) : QW'(det_q);
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DFIN;
        end
        S_DFIN: begin
          if (dcnt_q != CntW'(DivW)) begin
            if (rem_sh >= {1'b0, den_q}) begin
              rem_q <= QW'(rem_sh - {1'b0, den_q});
              nq_q  <= {nq_q[DivW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh[QW-1:0];
              nq_q  <= {nq_q[DivW-2:0], 1'b0};
            end
            dcnt_q <= dcnt_q + CntW'(1);
          end else begin
            out_val_q <= sat32(AccW'(qsgn));
            state_q   <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_axis_tready_i) begin
            if (j_q == LW'(DIM - 1)) begin
              j_q <= '0;
              if (i_q == LW'(DIM - 1)) begin
                i_q     <= '0;
                state_q <= S_LOAD;
              end else begin
                i_q     <= i_q + LW'(1);
                state_q <= S_NEXT;
              end
            end else begin
              j_q     <= j_q + LW'(1);
              state_q <= S_NEXT;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  logic out_last;
  assign out_last        = (i_q == LW'(DIM - 1)) && (j_q == LW'(DIM - 1));
  assign s_axis_tready_o = (state_q == S_LOAD);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = {4'b0000, det_q, 2'(j_q), 2'(i_q), out_val_q};
  assign m_axis_tuser_o  = sing_q;
  assign m_axis_tlast_o  = out_last;

endmodule

`default_nettype wire

// File: tb/sv/small_matrix_inverse_adjugate_top_tb.sv
// ----------------------------------------------------------------------------
// small_matrix_inverse_adjugate_top_tb: self-checking bench for the inverse
// Streams 4x4 Q16.16 matrices in, predicts inverse/determinant and checks
// every output transaction field by field with random gaps on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module small_matrix_inverse_adjugate_top_tb import smia_pkg::*; ();

  localparam int Dim   = DimDef;
  localparam int Cells = Dim * Dim;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] det;
    logic               singular;
    logic               last;
  } inv_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [71:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        m_axis_tlast_o;

  small_matrix_inverse_adjugate_top #(.DIM(Dim)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o,
    .m_axis_tuser_o, .m_axis_tlast_o
  );

  logic [31:0]  element_q[$];     // elements waiting to be sent
  inv_result_t  inverse_q[$];     // predicted output transactions
  logic [31:0]  mat[Cells];       // predictor's copy of the matrix store
  int           load_cnt;
  int           fails;
  int           hold_off;         // long receiver stall, cycles left
  bit           hold_armed;

  // ---- predictor ------------------------------------------------------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fdiv16(longint x);
    longint q;
    q = x / 65536;
    if (x < 0 && (x % 65536) != 0) q -= 1;
    return q;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return fdiv16(a * b + 32768);
  endfunction

  function automatic longint elem(int r, int c);
    return longint'($signed(mat[r*Dim+c]));
  endfunction

  // determinant of the minor built from rows r0.. and the column mask
  function automatic longint minor_det(int n, int r0, logic [7:0] cmask);
    longint acc, term;
    int k, c;
    if (n == 0) return 65536;
    acc = 0;
    k = 0;
    for (c = 0; c < Dim; c++) begin
      if (cmask[c]) begin
        if (n == 1) return elem(r0, c);
        term = qmul(elem(r0, c), minor_det(n-1, r0+1, cmask & ~(8'd1 << c)));
        if (k & 1) acc -= term; else acc += term;
        k++;
      end
    end
    return clamp32(acc);
  endfunction

  // cofactor (r,c): rows other than r, taken in order
  function automatic longint cofac(int r, int c);
    logic [31:0] keep[Cells];
    longint d;
    int i, j, m;
    for (i = 0; i < Cells; i++) keep[i] = mat[i];
    m = 0;
    for (i = 0; i < Dim; i++)
      if (i != r) begin
        for (j = 0; j < Dim; j++) mat[m*Dim+j] = keep[i*Dim+j];
        m++;
      end
    d = minor_det(Dim-1, 0, ((8'd1 << Dim) - 1) & ~(8'd1 << c));
    for (i = 0; i < Cells; i++) mat[i] = keep[i];
    if ((r + c) & 1) d = -d;
    return clamp32(d);
  endfunction

  function automatic longint qdiv(longint c, longint d);
    longint num, q, rm, ar, ad;
    num = c * 65536;
    q = num / d;
    rm = num % d;
    ar = rm < 0 ? -rm : rm;
    ad = d < 0 ? -d : d;
    if (2 * ar >= ad) begin
      if ((num < 0) != (d < 0)) q -= 1; else q += 1;
    end
    return clamp32(q);
  endfunction

  task automatic predict_element(logic [31:0] e);
    longint det, v;
    inv_result_t res;
    int i, j;
    mat[load_cnt] = e;
    load_cnt++;
    if (load_cnt < Cells) return;
    load_cnt = 0;
    det = minor_det(Dim, 0, (8'd1 << Dim) - 1);
    for (i = 0; i < Dim; i++)
      for (j = 0; j < Dim; j++) begin
        v = (det == 0) ? elem(i, j) : qdiv(cofac(j, i), det);
        res.value = v[31:0];
        res.row = i[1:0];
        res.col = j[1:0];
        res.det = det[31:0];
        res.singular = (det == 0);
        res.last = (i == Dim-1) && (j == Dim-1);
        inverse_q.insert(inverse_q.size(), res);
      end
  endtask

  // ---- clock, reset, limit --------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---- driver: predict on acceptance, random gaps ---------------------------
  int gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      gap = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_element(s_axis_tdata_i);
        void'(element_q.pop_front());
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (gap > 0) begin
        gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (element_q.size() > 0) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= element_q[0];
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---- one long hold-off once the first result shows up ---------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_armed <= 1'b1;
      hold_off   <= 0;
    end else if (hold_armed && m_axis_tvalid_o) begin
      hold_armed <= 1'b0;
      hold_off   <= 3000;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // ---- monitor: compare each output transaction, random stalls --------------
  int stall;
  always @(posedge clk_i or negedge rst_ni) begin
    inv_result_t got, exp_r;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.value = m_axis_tdata_o[31:0];
        got.row = m_axis_tdata_o[33:32];
        got.col = m_axis_tdata_o[35:34];
        got.det = m_axis_tdata_o[67:36];
        got.singular = m_axis_tuser_o;
        got.last = m_axis_tlast_o;
        if (inverse_q.size() == 0) begin
          $error("unexpected output transaction value=%0d", got.value);
          fails++;
        end else begin
          exp_r = inverse_q.pop_front();
          if (got.value !== exp_r.value) begin
            $error("value: expected %0d, got %0d", exp_r.value, got.value); fails++;
          end
          if (got.row !== exp_r.row) begin
            $error("row: expected %0d, got %0d", exp_r.row, got.row); fails++;
          end
          if (got.col !== exp_r.col) begin
            $error("col: expected %0d, got %0d", exp_r.col, got.col); fails++;
          end
          if (got.det !== exp_r.det) begin
            $error("det_value: expected %0d, got %0d", exp_r.det, got.det); fails++;
          end
          if (got.singular !== exp_r.singular) begin
            $error("singular: expected %0d, got %0d", exp_r.singular, got.singular);
            fails++;
          end
          if (got.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, got.last); fails++;
          end
        end
      end
      if (hold_off > 0) begin
        m_axis_tready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 4) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
      end
    end
  end

  // ---- stimulus -------------------------------------------------------------
  task automatic push_matrix(int kind);
    int i, r, c;
    logic [31:0] e;
    for (i = 0; i < Cells; i++) begin
      r = i / Dim;
      c = i % Dim;
      case (kind)
        0: e = (r == c) ? 32'h0001_0000 : 32'h0;                     // identity
        1: e = (r == c) ? 32'hFFFF_0000 : 32'h0;                     // minus identity
        2: e = (r == 0) ? 32'h0 : $urandom();                        // zero row
        3: e = (r == c) ? 32'h0000_0001 : 32'h0;                     // tiny diag
        4: e = (r == c) ? ((r & 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)  // extremes
                        : ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
        5: e = $urandom();                                           // full range
        6: e = (r == c) ? $urandom_range(32'h8000, 32'h40000)
                        : $signed($urandom_range(0, 32'h8000)) - 32'sh4000;
        default: e = $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
      endcase
      element_q.insert(element_q.size(), e);
    end
  endtask

  initial begin
    int n, t;
    fails = 0;
    load_cnt = 0;
    for (n = 0; n < Cells; n++) mat[n] = '0;
    wait (rst_ni === 1'b1);
    // directed: identity, extreme, singular, negated, tiny; then random incl. full-range
    push_matrix(0);
    push_matrix(4);
    push_matrix(2);
    push_matrix(1);
    push_matrix(3);
    for (n = 0; n < 8; n++) push_matrix(5 + (n % 3));
    wait (element_q.size() == 0 && !s_axis_tvalid_i);
    wait (inverse_q.size() == 0);
    t = 0;
    while (t < 2000) begin
      @(posedge clk_i);
      t++;
    end
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
